@@ rtl/u8esc_pkg.sv @@
// Package: shared types, character codes and hex helper for the UTF-8 escape block.
`default_nettype none

package u8esc_pkg;

  localparam int unsigned CpW       = 21;  // code point width
  localparam int unsigned UnitW     = 16;  // one UTF-16 unit
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  localparam logic [6:0] CHAR_BSLASH = 7'h5C;
  localparam logic [6:0] CHAR_U      = 7'h75;

  // Character positions within one six-character group
  localparam logic [2:0] POS_BSLASH = 3'd0;
  localparam logic [2:0] POS_U      = 3'd1;
  localparam logic [2:0] POS_HEX3   = 3'd2;
  localparam logic [2:0] POS_HEX2   = 3'd3;
  localparam logic [2:0] POS_HEX1   = 3'd4;
  localparam logic [2:0] POS_HEX0   = 3'd5;

  localparam logic [CpW-1:0] SuppBase  = 21'h10000;
  localparam logic [5:0]     HiSurrTag = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]     LoSurrTag = 6'b110111;  // 0xDC00 >> 10

  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] cp;
  } push_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h57 + {3'b000, nib};  // 'a' - 10
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/u8esc_front.sv @@
// Front end: classifies UTF-8 bytes and gathers finished code points.
`default_nettype none

module u8esc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              end_i,
  output u8esc_pkg::push_t       push_o
);
  import u8esc_pkg::*;

  logic [CpW-1:0] acc_q, acc_d, acc_n;
  logic [1:0]     left_q, left_d, left_n;
  logic           done;

  always_comb begin
    acc_n  = acc_q;
    left_n = left_q;
    done   = 1'b0;
    if (left_q != 2'd0) begin
      acc_n  = {acc_q[CpW-7:0], byte_i[5:0]};
      left_n = left_q - 2'd1;
      done   = (left_q == 2'd1);
    end else if (!byte_i[7]) begin
      acc_n = {13'd0, byte_i};
      done  = 1'b1;
    end else if (byte_i[7:5] == 3'b110) begin
      acc_n  = {16'd0, byte_i[4:0]};
      left_n = 2'd1;
    end else if (byte_i[7:4] == 4'b1110) begin
      acc_n  = {17'd0, byte_i[3:0]};
      left_n = 2'd2;
    end else if (byte_i[7:3] == 5'b11110) begin
      acc_n  = {18'd0, byte_i[2:0]};
      left_n = 2'd3;
    end
  end

  always_comb begin
    acc_d       = acc_q;
    left_d      = left_q;
    push_o.valid = 1'b0;
    push_o.cp    = acc_n;
    if (accept_i) begin
      if (done) begin
        push_o.valid = 1'b1;
        acc_d        = '0;
        left_d       = left_n;
      end else if (end_i) begin
        // string ended mid-sequence: drop it
        acc_d  = '0;
        left_d = 2'd0;
      end else begin
        acc_d  = acc_n;
        left_d = left_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      left_q <= 2'd0;
    end else begin
      acc_q  <= acc_d;
      left_q <= left_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/u8esc_fifo.sv @@
// Small code point queue between the front end and the emitter.
`default_nettype none

module u8esc_fifo (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  u8esc_pkg::push_t              push_i,
  input  wire logic                     pop_i,
  output logic [u8esc_pkg::CpW-1:0]     data_o,
  output logic                          empty_o,
  output logic                          full_o
);
  import u8esc_pkg::*;

  logic [CpW-1:0]     mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QueuePtrW:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth));
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i.valid;
  assign do_pop  = pop_i;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.cp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |-> !do_push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |-> !empty_o)
    else $error("queue read while empty");
  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count lost a word");

endmodule

`default_nettype wire

@@ rtl/u8esc_back.sv @@
// Emitter: turns code points into backslash-u escape text, one character a cycle while out_ready_i is high.
`default_nettype none

module u8esc_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [u8esc_pkg::CpW-1:0] cp_i,
  input  wire logic                  empty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [6:0]                 out_char_o,
  output logic                       out_last_o
);
  import u8esc_pkg::*;

  logic             busy_q, busy_d;
  logic             big_q, big_d;
  logic             grp_q, grp_d;
  logic [2:0]       k_q, k_d;
  logic [UnitW-1:0] unit0_q, unit0_d, unit1_q, unit1_d;
  logic             ov_q, ov_d;
  logic [6:0]       ch_q, ch_d;
  logic             lst_q, lst_d;

  logic             adv, last_char, big_in;
  logic [CpW-1:0]   off;
  logic [UnitW-1:0] unit;
  logic [3:0]       nib;
  logic [6:0]       ch_n;

  assign adv       = busy_q && (!ov_q || out_ready_i);
  assign last_char = (k_q == POS_HEX0) && (grp_q || !big_q);
  assign pop_o     = !empty_i && (!busy_q || (adv && last_char));
  assign big_in    = |cp_i[CpW-1:UnitW];
  assign off       = cp_i - SuppBase;
  assign unit      = grp_q ? unit1_q : unit0_q;

  always_comb begin
    nib  = unit[3:0];
    ch_n = CHAR_BSLASH;
    unique case (k_q)
      POS_BSLASH: ch_n = CHAR_BSLASH;
      POS_U:      ch_n = CHAR_U;
      POS_HEX3: begin nib = unit[15:12]; ch_n = hex_char(nib); end
      POS_HEX2: begin nib = unit[11:8];  ch_n = hex_char(nib); end
      POS_HEX1: begin nib = unit[7:4];   ch_n = hex_char(nib); end
      POS_HEX0: begin nib = unit[3:0];   ch_n = hex_char(nib); end
      default:  ch_n = CHAR_BSLASH;
    endcase
  end

  always_comb begin
    busy_d  = busy_q;
    big_d   = big_q;
    grp_d   = grp_q;
    k_d     = k_q;
    unit0_d = unit0_q;
    unit1_d = unit1_q;
    ov_d    = ov_q;
    ch_d    = ch_q;
    lst_d   = lst_q;
    if (adv) begin
      ov_d  = 1'b1;
      ch_d  = ch_n;
      lst_d = last_char;
      if (k_q == POS_HEX0) begin
        k_d   = POS_BSLASH;
        grp_d = 1'b1;
        if (last_char) begin
          busy_d = 1'b0;
        end
      end else begin
        k_d = k_q + 3'd1;
      end
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (pop_o) begin
      busy_d  = 1'b1;
      big_d   = big_in;
      grp_d   = 1'b0;
      k_d     = POS_BSLASH;
      unit0_d = big_in ? {HiSurrTag, off[19:10]} : cp_i[UnitW-1:0];
      unit1_d = {LoSurrTag, off[9:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    unit0_q <= unit0_d;
    unit1_q <= unit1_d;
    ch_q    <= ch_d;
    lst_q   <= lst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      big_q  <= 1'b0;
      grp_q  <= 1'b0;
      k_q    <= POS_BSLASH;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      big_q  <= big_d;
      grp_q  <= grp_d;
      k_q    <= k_d;
      ov_q   <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = ch_q;
  assign out_last_o  = lst_q;

  a_small_one_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !big_q |-> !grp_q)
    else $error("second group for a code point below 0x10000");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= POS_HEX0)
    else $error("character position out of range");
  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> busy_q && k_q == POS_BSLASH && !grp_q)
    else $error("pop did not start a new escape");

endmodule

`default_nettype wire

@@ rtl/utf8_to_unicode_escape.sv @@
// Top level: UTF-8 byte stream in, JSON backslash-u escape text out.
// Path: a byte that completes a code point gives its first character after the queue write
//   on its acceptance edge, the emitter load and the emitter output register, in that order.
// Throughput: one character per cycle while the output is ready; six characters per code point
//   up to FFFF, twelve above; bytes are taken one per cycle while the 4-entry code point queue has room.
// Reset: rst_ni clears the gathered sequence, the queue and the emitter at once.
`default_nettype none

module utf8_to_unicode_escape (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input byte stream
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] byte_in
  input  wire logic       s_axis_tlast_i,   // string_end
  // escape text stream
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [6:0] char_out, [7] zero
  output logic            m_axis_tlast_o    // run_last
);
  import u8esc_pkg::*;

  push_t          push;
  logic [CpW-1:0] q_cp;
  logic           q_empty, q_full, q_pop;
  logic           in_word;
  logic [6:0]     char_out;

  // The front end only needs queue room; a byte that finishes nothing pushes nothing.
  assign s_axis_tready_o = !q_full;
  assign in_word         = s_axis_tvalid_i && s_axis_tready_o;

  u8esc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_word),
    .byte_i   (s_axis_tdata_i),
    .end_i    (s_axis_tlast_i),
    .push_o   (push)
  );

  u8esc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .data_o  (q_cp),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Emitter pops the next code point on the cycle its last character is loaded,
  // so escapes follow each other without a gap.
  u8esc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cp_i        (q_cp),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (char_out),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, char_out};

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for utf8_to_unicode_escape: queued byte driver, escape-text monitor and checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u8esc_pkg::*;

  // One character of escape text as the block should emit it
  typedef struct {
    logic [6:0] ch;
    logic       last;
  } esc_char_t;

  // One byte waiting to be offered; hold_for_drain stalls the sender until all text is out
  typedef struct {
    logic [7:0] data;
    logic       str_end;
    logic       hold_for_drain;
  } utf8_byte_t;

  // Directed bytes, {string_end, byte}
  localparam int NumDirected = 28;
  localparam logic [8:0] DirectedBytes [NumDirected] = '{
    9'h000, 9'h17F,                   // ASCII extremes, string end on a whole char
    9'h0C0, 9'h080,                   // overlong zero
    9'h0DF, 9'h0BF,                   // largest two-byte value
    9'h0EF, 9'h0BF, 9'h0BF,           // FFFF
    9'h0ED, 9'h0A0, 9'h080,           // surrogate value D800, escaped as is
    9'h0F0, 9'h090, 9'h080, 9'h080,   // 10000, smallest surrogate pair
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,   // 1FFFFF, past the Unicode range
    9'h080, 9'h0F8,                   // invalid leads, dropped
    9'h0C3, 9'h041,                   // continuation with wrong top bits taken anyway
    9'h0E2, 9'h182,                   // string ends inside a sequence
    9'h1F0,                           // string ends on a lone lead
    9'h041                            // recovery
  };
  localparam int RandomItems = 180;
  localparam int HoldCycles  = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic       m_tready = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;

  utf8_byte_t pending_bytes_q[$];
  esc_char_t  escape_text_q[$];

  // predictor state
  logic [CpW-1:0] cp_accum  = '0;
  logic [1:0]     cont_left = '0;

  int fail_count    = 0;
  int bytes_offered = 0;
  int bytes_taken   = 0;
  int burst_left    = 1;
  int gap_left      = 0;
  int rx_cycle      = 0;
  int rx_mode       = 0;
  int hold_left     = 0;
  int hold_idx      = 0;
  int item_count    = 0;
  logic drain_next  = 1'b0;

  utf8_to_unicode_escape dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? (7'h30 + 7'(nib)) : (7'h61 + 7'(nib) - 7'd10);
  endfunction

  // Queue the six characters of one backslash-u group
  task automatic push_group(input logic [UnitW-1:0] unit, input logic ends_run);
    logic [6:0] txt [6];
    txt[0] = CHAR_BSLASH;
    txt[1] = CHAR_U;
    txt[2] = hex_ascii(unit[15:12]);
    txt[3] = hex_ascii(unit[11:8]);
    txt[4] = hex_ascii(unit[7:4]);
    txt[5] = hex_ascii(unit[3:0]);
    for (int k = 0; k < 6; k++) begin
      escape_text_q.insert(escape_text_q.size(),
                           esc_char_t'{ch: txt[k], last: ends_run && (k == 5)});
    end
  endtask

  // Gather one UTF-8 byte; queue escape text once a code point is complete
  task automatic decode_utf8_byte(input logic [7:0] b, input logic str_end);
    logic           complete;
    logic [CpW-1:0] offs;
    complete = 1'b0;
    if (cont_left != 2'd0) begin
      // continuation bits are never checked
      cp_accum  = {cp_accum[CpW-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      complete  = (cont_left == 2'd0);
    end else if (!b[7]) begin
      cp_accum = {14'd0, b[6:0]};
      complete = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      cp_accum  = {16'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_accum  = {17'd0, b[3:0]};
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_accum  = {18'd0, b[2:0]};
      cont_left = 2'd3;
    end
    // anything else at a sequence boundary is an invalid lead: ignored
    if (complete) begin
      if (cp_accum <= 21'h00FFFF) begin
        push_group(cp_accum[UnitW-1:0], 1'b1);
      end else begin
        offs = cp_accum - SuppBase;
        push_group({HiSurrTag, offs[19:10]}, 1'b0);
        push_group({LoSurrTag, offs[9:0]}, 1'b1);
      end
      cp_accum = '0;
    end else if (str_end) begin
      // partial sequence at string end is thrown away
      cp_accum  = '0;
      cont_left = '0;
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic str_end);
    pending_bytes_q.insert(pending_bytes_q.size(),
                           utf8_byte_t'{data: b, str_end: str_end,
                                        hold_for_drain: drain_next});
    drain_next = 1'b0;
  endtask

  // Queue an n-byte sequence, keeping its first keep bytes; any_cont lets the
  // continuation top bits be random
  task automatic add_sequence(input int n, input int keep, input logic str_end,
                              input logic any_cont);
    logic [7:0] b;
    for (int i = 0; i < keep; i++) begin
      b = 8'($urandom);
      if (i == 0) begin
        case (n)
          1:       b = {1'b0, b[6:0]};
          2:       b = {3'b110, b[4:0]};
          3:       b = {4'b1110, b[3:0]};
          default: b = {5'b11110, b[2:0]};
        endcase
      end else if (!any_cont) begin
        b = {2'b10, b[5:0]};
      end
      add_byte(b, (i == keep - 1) ? str_end : 1'b0);
      item_count++;
    end
  endtask

  // Sender: bursts of random length, random gaps, word held until taken
  always @(negedge clk_i) begin
    utf8_byte_t nxt;
    if (rst_ni && !(s_tvalid && (bytes_taken != bytes_offered))) begin
      if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_bytes_q.size() == 0 ||
                   (pending_bytes_q[0].hold_for_drain && escape_text_q.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        nxt = pending_bytes_q[0];
        pending_bytes_q.delete(0);
        s_tvalid      <= 1'b1;
        s_tdata       <= nxt.data;
        s_tlast       <= nxt.str_end;
        bytes_offered <= bytes_offered + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall pattern is redrawn periodically; two long hold-offs fill the block
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
      if (hold_left != 0) begin
        m_tready  <= 1'b0;
        hold_left <= hold_left - 1;
      end else if ((hold_idx == 0 && bytes_taken >= 60) ||
                   (hold_idx == 1 && bytes_taken >= 170)) begin
        m_tready  <= 1'b0;
        hold_left <= HoldCycles;
        hold_idx  <= hold_idx + 1;
      end else begin
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 0);
          2:       m_tready <= (rx_cycle % 4 == 0);
          default: m_tready <= ($urandom_range(0, 6) != 0);
        endcase
      end
    end
  end

  // Predict on every accepted byte, check every accepted character
  always @(posedge clk_i) begin : mon_proc
    esc_char_t want;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) begin
        decode_utf8_byte(s_tdata, s_tlast);
        bytes_taken <= bytes_taken + 1;
      end
      if (m_axis_tvalid_o && m_tready) begin
        if (escape_text_q.size() == 0) begin
          note_failure($sformatf("unexpected char %h last %b",
                                 m_axis_tdata_o, m_axis_tlast_o));
        end else begin
          want = escape_text_q[0];
          escape_text_q.delete(0);
          if (m_axis_tdata_o[6:0] !== want.ch || m_axis_tlast_o !== want.last ||
              m_axis_tdata_o[7] !== 1'b0) begin
            note_failure($sformatf("expected char %h last %b, got %h last %b",
                                   want.ch, want.last, m_axis_tdata_o, m_axis_tlast_o));
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int kind;
    logic [7:0] noise;
    for (int i = 0; i < NumDirected; i++) begin
      add_byte(DirectedBytes[i][7:0], DirectedBytes[i][8]);
    end
    drain_next = 1'b1;
    while (item_count < RandomItems) begin
      if (item_count >= 105 && item_count < 110) drain_next = 1'b1;
      kind = $urandom_range(0, 19);
      if (kind < 7) begin
        add_sequence(1, 1, $urandom_range(0, 7) == 0, 1'b0);
      end else if (kind < 17) begin
        add_sequence((kind - 7) / 3 + 2, (kind - 7) / 3 + 2, $urandom_range(0, 7) == 0, 1'b0);
      end else if (kind == 17) begin
        // sequence cut short by string end
        kind = $urandom_range(2, 4);
        add_sequence(kind, $urandom_range(1, kind - 1), 1'b1, 1'b0);
      end else if (kind == 18) begin
        noise = 8'($urandom);
        add_byte(noise, 1'($urandom_range(0, 1)));
        if (!(noise inside {[8'h80:8'hBF], [8'hF8:8'hFF]})) item_count++;
      end else begin
        kind = $urandom_range(2, 4);
        add_sequence(kind, kind, $urandom_range(0, 7) == 0, 1'b1);
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_bytes_q.size() != 0 || bytes_taken != bytes_offered ||
           escape_text_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (24) @(posedge clk_i);
    if (fail_count == 0 && escape_text_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/u8esc_pkg.sv
rtl/u8esc_front.sv
rtl/u8esc_fifo.sv
rtl/u8esc_back.sv
rtl/utf8_to_unicode_escape.sv
tb/testbench.sv
